// ===== src/cfa_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// cfa_pkg: shared types and constants
// Item, configuration and sequencer types, plus fixed-point constants.
// ---------------------------------------------------------------------------
package cfa_pkg;

    localparam int          QUEUE_DEPTH  = 2;
    localparam int          ATAN_LEN     = 24;
    localparam logic [16:0] Q16_ONE      = 17'd65536;
    localparam logic signed [31:0] DEG180_Q16 = 32'sd11796480;
    // 65536 / 1000000 reduces to 1024 / 15625 after taking out 2^6.
    localparam logic [14:0] DIV_CONST    = 15'd15625;
    localparam logic [12:0] DIV_BIAS     = 13'd7812;
    // Reciprocal of 15625 scaled by 2^41 and rounded up; it gives the exact
    // quotient for any dividend below 2^27.
    localparam logic [27:0] DIV_RECIP    = 28'd140737489;
    // Four 13-bit digits, each an estimate step then a remainder step.
    localparam int          DIV_STEPS    = 8;

    localparam logic [1:0]  REG_ALPHA    = 2'd0;
    localparam logic [1:0]  REG_SENS     = 2'd1;
    localparam logic [1:0]  REG_DT       = 2'd2;

    localparam logic [16:0] ALPHA_RESET  = 17'd64225;
    localparam logic [9:0]  SENS_RESET   = 10'd70;
    localparam logic [9:0]  DT_RESET     = 10'd10;

    typedef struct packed {
        logic               action;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic        [15:0] dt;
    } t_item;

    typedef struct packed {
        logic [16:0] alpha;
        logic [9:0]  sens;
        logic [9:0]  default_dt;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GMUL,
        S_SQY,
        S_SQZ,
        S_SQRT,
        S_CR_INIT,
        S_CR_RUN,
        S_CP_INIT,
        S_CP_RUN,
        S_WAIT_DIV,
        S_GADD,
        S_BL_G,
        S_BL_A,
        S_BL_R,
        S_DONE
    } t_state;

    function automatic logic signed [31:0] atan_deg(input logic [4:0] idx);
        logic signed [31:0] v;
        unique case (idx)
            5'd0:  v = 32'sd2949120;
            5'd1:  v = 32'sd1740967;
            5'd2:  v = 32'sd919879;
            5'd3:  v = 32'sd466945;
            5'd4:  v = 32'sd234379;
            5'd5:  v = 32'sd117304;
            5'd6:  v = 32'sd58666;
            5'd7:  v = 32'sd29335;
            5'd8:  v = 32'sd14668;
            5'd9:  v = 32'sd7334;
            5'd10: v = 32'sd3667;
            5'd11: v = 32'sd1833;
            5'd12: v = 32'sd917;
            5'd13: v = 32'sd458;
            5'd14: v = 32'sd229;
            5'd15: v = 32'sd115;
            5'd16: v = 32'sd57;
            5'd17: v = 32'sd29;
            5'd18: v = 32'sd14;
            5'd19: v = 32'sd7;
            5'd20: v = 32'sd4;
            5'd21: v = 32'sd2;
            5'd22: v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [31:0] r;
        if (v > 50'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -50'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/cfa_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// cfa_front: item intake and configuration
// Holds the configuration registers and the stored timestamp, works out dt
// for each accepted item and pushes the item into the queue.
// ---------------------------------------------------------------------------
module cfa_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_action,
    input  wire logic signed [15:0] i_accel_x,
    input  wire logic signed [15:0] i_accel_y,
    input  wire logic signed [15:0] i_accel_z,
    input  wire logic signed [15:0] i_gyro_x,
    input  wire logic signed [15:0] i_gyro_y,
    input  wire logic signed [15:0] i_gyro_z,
    input  wire logic        [31:0] i_time_ms,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic        [1:0]  i_cfg_index,
    input  wire logic        [16:0] i_cfg_data,
    input  wire logic               i_q_full,
    output logic                    o_push,
    output cfa_pkg::t_item          o_item,
    output cfa_pkg::t_cfg           o_cfg
);
    import cfa_pkg::*;

    logic [31:0] r_last_time;
    t_cfg        r_cfg;
    logic [31:0] diff;
    logic [15:0] dt;

    assign o_in_ready  = !i_q_full;
    assign o_cfg_ready = 1'b1;
    assign o_push      = i_in_valid && !i_q_full;
    assign o_cfg       = r_cfg;

    always_comb begin
        diff = i_time_ms - r_last_time;
        if (r_last_time == 32'd0) begin
            dt = 16'(r_cfg.default_dt);
        end else if (diff > 32'd65535) begin
            dt = 16'hFFFF;
        end else begin
            dt = diff[15:0];
        end
        o_item.action  = i_action;
        o_item.accel_x = i_accel_x;
        o_item.accel_y = i_accel_y;
        o_item.accel_z = i_accel_z;
        o_item.gyro_x  = i_gyro_x;
        o_item.gyro_y  = i_gyro_y;
        o_item.gyro_z  = i_gyro_z;
        o_item.dt      = dt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time <= 32'd0;
        end else if (o_push) begin
            r_last_time <= i_action ? 32'd0 : i_time_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alpha      <= ALPHA_RESET;
            r_cfg.sens       <= SENS_RESET;
            r_cfg.default_dt <= DT_RESET;
        end else if (i_cfg_valid) begin
            priority case (i_cfg_index)
                REG_ALPHA: r_cfg.alpha      <= i_cfg_data;
                REG_SENS:  r_cfg.sens       <= i_cfg_data[9:0];
                REG_DT:    r_cfg.default_dt <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== src/cfa_queue.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// cfa_queue: item queue
// A short first-in first-out store between intake and the sequencer.
// ---------------------------------------------------------------------------
module cfa_queue (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  cfa_pkg::t_item i_item,
    input  wire logic      i_pop,
    output logic           o_full,
    output logic           o_valid,
    output cfa_pkg::t_item o_item
);
    import cfa_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_item         r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== src/cfa_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// cfa_back: attitude sequencer
// Runs gyro integration, the magnitude square root, two CORDIC atan2 passes
// and the blend for one item at a time, and holds the result register.
// ---------------------------------------------------------------------------
module cfa_back #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  cfa_pkg::t_cfg           i_cfg,
    input  wire logic               i_q_valid,
    input  cfa_pkg::t_item          i_item,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [31:0]      o_roll_deg,
    output logic signed [31:0]      o_pitch_deg,
    output logic signed [31:0]      o_yaw_deg
);
    import cfa_pkg::*;

    localparam int         N_STEPS   = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
    localparam logic [4:0] LAST_STEP = 5'(N_STEPS - 1);
    localparam logic [5:0] DIV_LAST  = 6'(DIV_STEPS - 1);

    t_state r_state, n_state;

    t_item              r_item;
    logic [4:0]         r_cnt;
    logic signed [31:0] r_roll, r_pitch, r_yaw;
    logic signed [31:0] r_groll, r_gpitch;
    logic signed [31:0] r_acc_roll, r_acc_pitch;
    logic               r_sel;

    logic [41:0]        r_gmag [3];
    logic [13:0]        r_drem [3];
    logic [51:0]        r_dnum [3];
    logic [26:0]        r_dv   [3];
    logic [12:0]        r_dqd  [3];
    logic [37:0]        r_dsh  [3];
    logic [5:0]         r_div_cnt;
    logic               r_div_busy;

    logic [31:0]        r_sv, r_res, r_bit;
    logic signed [35:0] r_cx, r_cy;
    logic signed [31:0] r_cz;
    logic               r_czero;
    logic signed [49:0] r_num;

    logic               r_out_valid;
    logic signed [31:0] r_out_roll, r_out_pitch, r_out_yaw;

    // combinational datapath
    logic [1:0]         lane;
    logic signed [15:0] raw_sel;
    logic [15:0]        raw_abs;
    logic [25:0]        gm_a;
    logic [15:0]        gm_b;
    logic [41:0]        gm_p;
    logic signed [15:0] sq_op;
    logic [31:0]        sq_p;
    logic [31:0]        sq_try;
    logic signed [16:0] c_y_in, c_x_in;
    logic signed [35:0] c_x36, c_y36, c_xs, c_ys;
    logic [26:0]        d_v    [3];
    logic [54:0]        d_prod [3];
    logic [26:0]        d_sub  [3];
    logic signed [39:0] delta [3];
    logic [16:0]        alpha_c;
    logic signed [31:0] bl_g, bl_acc;
    logic signed [49:0] bl_prod;
    logic [49:0]        rnd_mag;
    logic [33:0]        rnd_q;
    logic signed [49:0] rnd_val;
    logic               out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_roll_deg  = r_out_roll;
    assign o_pitch_deg = r_out_pitch;
    assign o_yaw_deg   = r_out_yaw;

    always_comb begin
        lane = r_cnt[2:1];
        unique case (lane)
            2'd0:    raw_sel = r_item.gyro_x;
            2'd1:    raw_sel = r_item.gyro_y;
            default: raw_sel = r_item.gyro_z;
        endcase
        raw_abs = raw_sel[15] ? 16'(-raw_sel) : raw_sel;
        if (!r_cnt[0]) begin
            gm_a = 26'(raw_abs);
            gm_b = 16'(i_cfg.sens);
        end else begin
            gm_a = r_gmag[lane][25:0];
            gm_b = r_item.dt;
        end
        gm_p = 42'(gm_a) * 42'(gm_b);

        sq_op  = (r_state == S_SQY) ? r_item.accel_y : r_item.accel_z;
        sq_p   = 32'(sq_op) * 32'(sq_op);
        sq_try = r_res + r_bit;

        if (r_state == S_CR_INIT) begin
            c_y_in = 17'(r_item.accel_y);
            c_x_in = 17'(r_item.accel_z);
        end else begin
            c_y_in = 17'(r_item.accel_x);
            c_x_in = $signed({1'b0, r_res[15:0]});
        end
        c_x36 = 36'(c_x_in) <<< 16;
        c_y36 = 36'(c_y_in) <<< 16;
        c_xs  = r_cx >>> r_cnt;
        c_ys  = r_cy >>> r_cnt;

        // Each 13-bit quotient digit: estimate by reciprocal,
        // then take the remainder.
        for (int k = 0; k < 3; k++) begin
            d_v[k]    = {r_drem[k], r_dnum[k][51:39]};
            d_prod[k] = 55'(d_v[k]) * 55'(DIV_RECIP);
            d_sub[k]  = r_dv[k] - 27'(r_dqd[k]) * 27'(DIV_CONST);
        end
        delta[0] = r_item.gyro_x[15] ? -$signed({2'b00, r_dsh[0]}) : $signed({2'b00, r_dsh[0]});
        delta[1] = r_item.gyro_y[15] ? -$signed({2'b00, r_dsh[1]}) : $signed({2'b00, r_dsh[1]});
        delta[2] = r_item.gyro_z[15] ? -$signed({2'b00, r_dsh[2]}) : $signed({2'b00, r_dsh[2]});

        alpha_c = (i_cfg.alpha > Q16_ONE) ? Q16_ONE : i_cfg.alpha;
        bl_g    = r_sel ? r_gpitch : r_groll;
        bl_acc  = r_sel ? r_acc_pitch : r_acc_roll;
        if (r_state == S_BL_G) begin
            bl_prod = 50'($signed({1'b0, alpha_c})) * 50'(bl_g);
        end else begin
            bl_prod = 50'($signed({1'b0, 17'(Q16_ONE - alpha_c)})) * 50'(bl_acc);
        end
        rnd_mag = r_num[49] ? 50'(-r_num) : 50'(r_num);
        rnd_q   = 34'((rnd_mag + 50'd32768) >> 16);
        rnd_val = r_num[49] ? -$signed(50'(rnd_q)) : $signed(50'(rnd_q));
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_q_valid) n_state = i_item.action ? S_DONE : S_GMUL;
            S_GMUL:     if (r_cnt == 5'd5) n_state = S_SQY;
            S_SQY:      n_state = S_SQZ;
            S_SQZ:      n_state = S_SQRT;
            S_SQRT:     if (r_cnt == 5'd15) n_state = S_CR_INIT;
            S_CR_INIT:  n_state = S_CR_RUN;
            S_CR_RUN:   if (r_cnt == LAST_STEP) n_state = S_CP_INIT;
            S_CP_INIT:  n_state = S_CP_RUN;
            S_CP_RUN:   if (r_cnt == LAST_STEP) n_state = S_WAIT_DIV;
            S_WAIT_DIV: if (!r_div_busy) n_state = S_GADD;
            S_GADD:     n_state = S_BL_G;
            S_BL_G:     n_state = S_BL_A;
            S_BL_A:     n_state = S_BL_R;
            S_BL_R:     n_state = r_sel ? S_DONE : S_BL_G;
            S_DONE:     if (out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_pop = (r_state == S_IDLE) && i_q_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // step counter and angle state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_sel   <= 1'b0;
            r_roll  <= '0;
            r_pitch <= '0;
            r_yaw   <= '0;
        end else begin
            if (n_state != r_state) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_sel <= 1'b0;
                    if (i_q_valid && i_item.action) begin
                        r_roll  <= '0;
                        r_pitch <= '0;
                        r_yaw   <= '0;
                    end
                end
                S_GADD: begin
                    r_yaw <= sat32(50'(r_yaw) + 50'(delta[2]));
                end
                S_BL_R: begin
                    if (r_sel) begin
                        r_pitch <= sat32(rnd_val);
                    end else begin
                        r_roll <= sat32(rnd_val);
                    end
                    r_sel <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // arithmetic payload
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) r_item <= i_item;
            end
            S_GMUL: begin
                r_gmag[lane] <= gm_p;
            end
            S_SQY: begin
                r_sv <= sq_p;
            end
            S_SQZ: begin
                r_sv  <= r_sv + sq_p;
                r_res <= '0;
                r_bit <= 32'h4000_0000;
            end
            S_SQRT: begin
                if (r_sv >= sq_try) begin
                    r_sv  <= r_sv - sq_try;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            S_CR_INIT, S_CP_INIT: begin
                r_czero <= (c_x_in == 17'sd0) && (c_y_in == 17'sd0);
                if (c_x_in < 0) begin
                    r_cz <= (c_y_in >= 0) ? DEG180_Q16 : -DEG180_Q16;
                    r_cx <= -c_x36;
                    r_cy <= -c_y36;
                end else begin
                    r_cz <= '0;
                    r_cx <= c_x36;
                    r_cy <= c_y36;
                end
            end
            S_CR_RUN, S_CP_RUN: begin
                if (!r_cy[35]) begin
                    r_cx <= r_cx + c_ys;
                    r_cy <= r_cy - c_xs;
                    r_cz <= r_cz + atan_deg(r_cnt);
                end else begin
                    r_cx <= r_cx - c_ys;
                    r_cy <= r_cy + c_xs;
                    r_cz <= r_cz - atan_deg(r_cnt);
                end
            end
            S_WAIT_DIV: begin
                r_acc_pitch <= r_czero ? 32'sd0 : -r_cz;
            end
            S_GADD: begin
                r_groll  <= sat32(50'(r_roll) + 50'(delta[0]));
                r_gpitch <= sat32(50'(r_pitch) + 50'(delta[1]));
            end
            S_BL_G: begin
                r_num <= bl_prod;
            end
            S_BL_A: begin
                r_num <= r_num + bl_prod;
            end
            default: ;
        endcase
        // The roll result is taken as the pitch pass starts.
        if (r_state == S_CP_INIT) begin
            r_acc_roll <= r_czero ? 32'sd0 : r_cz;
        end
    end

    // Gyro dividers run beside the square root.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_div_cnt  <= '0;
        end else if (r_state == S_SQY) begin
            r_div_busy <= 1'b1;
            r_div_cnt  <= '0;
        end else if (r_div_busy) begin
            r_div_cnt <= r_div_cnt + 1'b1;
            if (r_div_cnt == DIV_LAST) r_div_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (r_state == S_SQY) begin
                r_dnum[k] <= {r_gmag[k], 10'b0} + 52'(DIV_BIAS);
                r_drem[k] <= '0;
                r_dsh[k]  <= '0;
            end else if (r_div_busy) begin
                if (!r_div_cnt[0]) begin
                    r_dv[k]  <= d_v[k];
                    r_dqd[k] <= d_prod[k][53:41];
                end else begin
                    r_drem[k] <= d_sub[k][13:0];
                    r_dsh[k]  <= {r_dsh[k][24:0], r_dqd[k]};
                    r_dnum[k] <= {r_dnum[k][38:0], 13'b0};
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out_roll  <= r_roll;
            r_out_pitch <= r_pitch;
            r_out_yaw   <= r_yaw;
        end
    end

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GADD) |-> !r_div_busy)
        else $error("gyro divider still busy at integration");

    a_sqrt_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT) |-> $onehot(r_bit))
        else $error("square root bit lost");

    a_cordic_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CR_RUN || r_state == S_CP_RUN) |-> !r_cx[35])
        else $error("CORDIC x went negative");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not loaded on completion");

endmodule
`default_nettype wire

// ===== src/complementary_filter_attitude_unit.sv =====
`default_nettype none
// A sample item passes from queue to result through the sequencer's gyro
// multiply, square root, two CORDIC passes, gyro add and blend; the gyro
// dividers run alongside the square root. A reset-action item goes straight
// to the result and zeroes the angles. One item is worked on at a time; a
// two-entry queue and the result register let intake and output stall apart.
// Reset (synchronous, active low) zeroes angles and stored time, loads defaults.
// ---------------------------------------------------------------------------
// complementary_filter_attitude_unit: IMU attitude filter
// Tilt from the accelerometer blended with gyro-integrated roll and pitch.
// ---------------------------------------------------------------------------
module complementary_filter_attitude_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_action,
    input  wire logic signed [15:0] i_accel_x,
    input  wire logic signed [15:0] i_accel_y,
    input  wire logic signed [15:0] i_accel_z,
    input  wire logic signed [15:0] i_gyro_x,
    input  wire logic signed [15:0] i_gyro_y,
    input  wire logic signed [15:0] i_gyro_z,
    input  wire logic        [31:0] i_time_ms,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic        [1:0]  i_cfg_index,
    input  wire logic        [16:0] i_cfg_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [31:0]      o_roll_deg,
    output logic signed [31:0]      o_pitch_deg,
    output logic signed [31:0]      o_yaw_deg
);
    import cfa_pkg::*;

    logic  push, pop, q_full, q_valid;
    t_item f_item, q_item;
    t_cfg  cfg;

    cfa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_accel_x   (i_accel_x),
        .i_accel_y   (i_accel_y),
        .i_accel_z   (i_accel_z),
        .i_gyro_x    (i_gyro_x),
        .i_gyro_y    (i_gyro_y),
        .i_gyro_z    (i_gyro_z),
        .i_time_ms   (i_time_ms),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_item      (f_item),
        .o_cfg       (cfg)
    );

    cfa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    cfa_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_valid   (q_valid),
        .i_item      (q_item),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_roll_deg  (o_roll_deg),
        .o_pitch_deg (o_pitch_deg),
        .o_yaw_deg   (o_yaw_deg)
    );

endmodule
`default_nettype wire
